@@ hdl/cid_four_pass_cipher_core_assert.svh @@
// assertion macros for the connection-id cipher core
`ifndef CID_FOUR_PASS_CIPHER_CORE_ASSERT_SVH
`define CID_FOUR_PASS_CIPHER_CORE_ASSERT_SVH
`ifndef SYNTH
`define CID_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("cid assertion failed");
`define CID_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("cid assertion failed");
`else
`define CID_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CID_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/cid_pkg.sv @@
// types, constants and aes byte functions for the connection-id cipher
package cid_pkg;
	localparam int unsigned BlkBits = 128;
	localparam int unsigned AesRounds = 10;
	localparam logic [4:0] SingleBlockLen = 5'd16;
	localparam logic [7:0] PassIdx1 = 8'h01;
	localparam logic [7:0] PassIdx2 = 8'h02;
	localparam logic [7:0] PassIdx3 = 8'h03;
	localparam logic [7:0] PassIdx4 = 8'h04;

	typedef logic [BlkBits-1:0] blk_t;

	// register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_KEY_UPPER = 2'd0,
		REG_KEY_LOWER = 2'd1,
		REG_PLAIN_LEN = 2'd2
	} reg_idx_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [AesRounds] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	// byte i of a block, byte 0 in the top bits
	function automatic logic [7:0] get_byte(input blk_t b, input int i);
		get_byte = b[BlkBits-1-8*i -: 8];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// sub bytes, shift rows, optional mix columns, add round key
	function automatic blk_t aes_round(input blk_t s, input blk_t rk, input logic last);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3;
		blk_t o;
		o = '0;
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[i + 4*c] = SBOX[get_byte(s, i + 4*((c + i) % 4))];
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			if (!last) begin
				t[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
				t[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
				t[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
				t[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
			end
		end
		for (int i = 0; i < 16; i++)
			o[BlkBits-1-8*i -: 8] = t[i];
		aes_round = o ^ rk;
	endfunction

	// next round key from the previous one
	function automatic blk_t key_step(input blk_t k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
		w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
		key_step = {w0, w1, w2, w3};
	endfunction
endpackage

@@ hdl/cid_aes_pipe.sv @@
// aes-128 encryption unrolled into eleven register stages, key expanded alongside
module cid_aes_pipe
	import cid_pkg::*;
#(
	parameter int unsigned TagW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  blk_t            in_blk,
	input  blk_t            in_key,
	input  logic [TagW-1:0] in_tag,
	output logic            out_vld,
	output blk_t            out_blk,
	output logic [TagW-1:0] out_tag
);
	localparam int unsigned Nst = AesRounds + 1;

	logic            vld_s [Nst];
	blk_t            blk_s [Nst];
	blk_t            key_s [Nst];
	logic [TagW-1:0] tag_s [Nst];

	// valid bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Nst; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			for (int i = 1; i < Nst; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// initial key add then one round per stage
	always_ff @(posedge clk) begin
		if (en) begin
			blk_s[0] <= in_blk ^ in_key;
			key_s[0] <= in_key;
			tag_s[0] <= in_tag;
			for (int r = 1; r < Nst; r++) begin
				key_s[r] <= key_step(key_s[r-1], RCON[r-1]);
				blk_s[r] <= aes_round(blk_s[r-1], key_step(key_s[r-1], RCON[r-1]),
					r == Nst - 1);
				tag_s[r] <= tag_s[r-1];
			end
		end
	end

	assign out_vld = vld_s[Nst-1];
	assign out_blk = blk_s[Nst-1];
	assign out_tag = tag_s[Nst-1];
endmodule

@@ hdl/cid_four_pass_cipher_core.sv @@
// top level: four-pass feistel / single-block aes-128 connection-id cipher
//
// channel  | dir | handshake         | payload
// s_axis   | in  | tvalid/tready     | tdata[151:0] plain a,b,c
// m_axis   | out | tvalid/tready     | tdata[151:0] cipher a,b,c
// cfg      | in  | cfg_valid/ready   | cfg_index[1:0], cfg_data[63:0]
//
// one item per cycle while m_axis is not stalled; path from s_axis to m_axis_tvalid:
// entry register, then four passes of an eleven-stage aes pipeline plus a fold
// register each, then the output register. a 16-byte item is encrypted
// in pass one and carried unchanged through the other three.
// a stall on m_axis freezes the whole pipe; s_axis_tready follows it.
// reset clears valid bits and sets the configuration registers: key zero, length eight.
module cid_four_pass_cipher_core
	import cid_pkg::*;
#(
	parameter int unsigned MAX_PLAIN_BYTES = 19
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [151:0] s_axis_tdata,  // plain_bytes_a, plain_bytes_b, plain_bytes_c
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [151:0] m_axis_tdata,  // cipher_bytes_a, cipher_bytes_b, cipher_bytes_c
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
`include "cid_four_pass_cipher_core_assert.svh"
	localparam int unsigned PB = 19*8;
	localparam logic [4:0] MaxLen = 5'(MAX_PLAIN_BYTES);

	typedef logic [PB-1:0] pb_t;

	logic [63:0] key_upper_q, key_lower_q;
	logic [4:0]  len_q;
	blk_t        key;
	logic [4:0]  len;
	logic        en;
	logic        ovld_q;
	pb_t         odata_q;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
			len_q <= 5'd8;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEY_UPPER: key_upper_q <= cfg_data;
				REG_KEY_LOWER: key_lower_q <= cfg_data;
				REG_PLAIN_LEN: len_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end
	assign key = {key_upper_q, key_lower_q};
	assign len = (len_q > MaxLen) ? MaxLen : len_q;

	// byte helpers over a 19-byte vector, byte 0 on top
	function automatic logic [7:0] pbyte(input pb_t v, input int i);
		pbyte = v[PB-1-8*i -: 8];
	endfunction

	// left half from plaintext, nibble cleared when odd
	function automatic blk_t left_half(input pb_t p, input logic [4:0] n);
		blk_t o;
		int h;
		o = '0;
		h = (int'(n) + 1) / 2;
		for (int i = 0; i < 10; i++)
			if (i < h) o[BlkBits-1-8*i -: 8] = pbyte(p, i);
		if (n[0] && h > 0) o[BlkBits-1-8*(h-1) -: 8] = o[BlkBits-1-8*(h-1) -: 8] & 8'hf0;
		left_half = o;
	endfunction

	// right half held in bytes 0..h-1
	function automatic blk_t right_half(input pb_t p, input logic [4:0] n);
		blk_t o;
		int h;
		o = '0;
		h = (int'(n) + 1) / 2;
		for (int i = 0; i < 10; i++)
			if (i < h) o[BlkBits-1-8*i -: 8] = pbyte(p, int'(n) - h + i);
		if (n[0]) o[BlkBits-1 -: 8] = o[BlkBits-1 -: 8] & 8'h0f;
		right_half = o;
	endfunction

	// expand: left at bytes 0..h-1 with idx in byte 15
	function automatic blk_t exp_l(input blk_t l, input logic [7:0] idx);
		exp_l = {l[BlkBits-1:8], idx};
	endfunction

	// expand: idx in byte 0, right at bytes 16-h..15
	function automatic blk_t exp_r(input blk_t r, input logic [4:0] n, input logic [7:0] idx);
		blk_t o;
		int h;
		o = '0;
		h = (int'(n) + 1) / 2;
		for (int i = 0; i < 10; i++)
			if (i < h) o[BlkBits-1-8*(16-h+i) -: 8] = r[BlkBits-1-8*i -: 8];
		o[BlkBits-1 -: 8] = idx;
		exp_r = o;
	endfunction

	// fold aes output into right half (truncate right)
	function automatic blk_t fold_r(input blk_t r, input blk_t x, input logic [4:0] n);
		blk_t o;
		int h;
		o = r;
		h = (int'(n) + 1) / 2;
		for (int i = 0; i < 10; i++)
			if (i < h) o[BlkBits-1-8*i -: 8] = r[BlkBits-1-8*i -: 8] ^ get_byte(x, 16-h+i);
		if (n[0]) o[BlkBits-1 -: 8] = o[BlkBits-1 -: 8] & 8'h0f;
		fold_r = o;
	endfunction

	// fold aes output into left half (truncate left)
	function automatic blk_t fold_l(input blk_t l, input blk_t x, input logic [4:0] n);
		blk_t o;
		int h;
		o = l;
		h = (int'(n) + 1) / 2;
		for (int i = 0; i < 10; i++)
			if (i < h) o[BlkBits-1-8*i -: 8] = l[BlkBits-1-8*i -: 8] ^ get_byte(x, i);
		if (n[0] && h > 0) o[BlkBits-1-8*(h-1) -: 8] = o[BlkBits-1-8*(h-1) -: 8] & 8'hf0;
		fold_l = o;
	endfunction

	// merge halves into the output byte vector
	function automatic pb_t merge(input blk_t l, input blk_t r, input logic [4:0] n);
		pb_t o;
		int h;
		o = '0;
		h = (int'(n) + 1) / 2;
		for (int i = 0; i < 10; i++)
			if (i < h) o[PB-1-8*i -: 8] = get_byte(l, i);
		for (int i = 0; i < 10; i++)
			if (i < h) o[PB-1-8*(int'(n)-h+i) -: 8] =
				o[PB-1-8*(int'(n)-h+i) -: 8] | get_byte(r, i);
		merge = o;
	endfunction

	// tag carried alongside each aes pass: left, right, length
	typedef struct packed {
		blk_t       l;
		blk_t       r;
		logic [4:0] n;
	} tag_t;
	localparam int unsigned TagW = $bits(tag_t);

	pb_t  pin;
	logic in_vld_s1;
	tag_t tag_s1;
	blk_t ablk_s1;

	assign en = !ovld_q || m_axis_tready;
	assign s_axis_tready = en;
	// byte vector with byte 0 on top: fields a, b, c sit from the low end of tdata
	assign pin = {s_axis_tdata[63:0], s_axis_tdata[127:64], s_axis_tdata[151:128]};

	// entry stage: split halves and expand for pass one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) in_vld_s1 <= 1'b0;
		else if (en) in_vld_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1.n <= len;
			if (len == SingleBlockLen) begin
				tag_s1.l <= '0;
				tag_s1.r <= '0;
				ablk_s1 <= pin[PB-1 -: BlkBits];
			end else begin
				tag_s1.l <= left_half(pin, len);
				tag_s1.r <= right_half(pin, len);
				ablk_s1 <= exp_l(left_half(pin, len), PassIdx1);
			end
		end
	end

	logic vld_p [5];
	blk_t blk_p [4];
	tag_t tag_p [5];
	logic vld_o [4];
	blk_t blk_o [4];
	tag_t tag_o [4];

	assign vld_p[0] = in_vld_s1;
	assign blk_p[0] = ablk_s1;
	assign tag_p[0] = tag_s1;

	// four aes passes with a fold register after each
	for (genvar g = 0; g < 4; g++) begin : g_pass
		cid_aes_pipe #(.TagW(TagW)) u_aes (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_vld(vld_p[g]), .in_blk(blk_p[g]), .in_key(key), .in_tag(tag_p[g]),
			.out_vld(vld_o[g]), .out_blk(blk_o[g]), .out_tag(tag_o[g])
		);
		tag_t nt;
		// single block: pass one result goes to the left half, later passes keep it
		always_comb begin
			nt = tag_o[g];
			if (tag_o[g].n == SingleBlockLen) begin
				if (g == 0) nt.l = blk_o[g];
			end else if (g % 2 == 0) begin
				nt.r = fold_r(tag_o[g].r, blk_o[g], tag_o[g].n);
			end else begin
				nt.l = fold_l(tag_o[g].l, blk_o[g], tag_o[g].n);
			end
		end
		logic vf_q;
		tag_t tf_q;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vf_q <= 1'b0;
			else if (en) vf_q <= vld_o[g];
		end
		always_ff @(posedge clk) begin
			if (en) tf_q <= nt;
		end
		assign vld_p[g+1] = vf_q;
		assign tag_p[g+1] = tf_q;

		// expanded block for the next pass
		if (g < 3) begin : g_next
			logic [7:0] nidx;
			blk_t bf_q;
			assign nidx = (g == 0) ? PassIdx2 : (g == 1) ? PassIdx3 : PassIdx4;
			always_ff @(posedge clk) begin
				if (en) begin
					if (g % 2 == 0) bf_q <= exp_r(nt.r, nt.n, nidx);
					else bf_q <= exp_l(nt.l, nidx);
				end
			end
			assign blk_p[g+1] = bf_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovld_q <= 1'b0;
		else if (en) ovld_q <= vld_p[4];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (tag_p[4].n == SingleBlockLen) odata_q <= {tag_p[4].l, 24'h0};
			else if (tag_p[4].n == 5'd0) odata_q <= '0;
			else odata_q <= merge(tag_p[4].l, tag_p[4].r, tag_p[4].n);
		end
	end

	assign m_axis_tvalid = ovld_q;
	assign m_axis_tdata = {odata_q[23:0], odata_q[87:24], odata_q[151:88]};

	`CID_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`CID_ASSERT_IMP(a_rdy, clk, arst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
	`CID_ASSERT_IMP(a_len, clk, arst_n, 1'b1, len <= MaxLen)
endmodule
